### sv/qenc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the quadrature encoder and button decoder.
// No dependencies; every other file in the project imports this package.
package qenc_pkg;

  // Operation codes carried by an input beat.
  typedef enum logic [1:0] {
    OP_TICK         = 2'd0,
    OP_READ_DETENTS = 2'd1,
    OP_READ_PRESS   = 2'd2,
    OP_INIT         = 2'd3
  } op_e;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 1;
  typedef enum logic [CfgIdxW-1:0] {
    CFG_STEPS_LOG2 = 1'b0,
    CFG_DEBOUNCE   = 1'b1
  } cfg_idx_e;

  localparam int unsigned CfgDataW  = 8;
  localparam int unsigned ShiftW    = 2;
  localparam int unsigned CountW    = 8;
  localparam int unsigned DebounceW = 8;
  localparam int unsigned PosW      = 2;

  localparam logic [ShiftW-1:0]    ShiftReset    = 2'd2;
  localparam logic [DebounceW-1:0] DebounceReset = 8'h3f;

  typedef logic [PosW-1:0] pos_t;

  // Gray decode of the two phases: phase A gives position 3, phase B then
  // toggles the low bit.
  function automatic pos_t gray_position(input logic a, input logic b);
    gray_position = {a, a ^ b};
  endfunction

endpackage

### sv/qenc_in_if.sv
`timescale 1ns / 1ps
// Input channel of the encoder decoder: valid, ready and one operation beat.
// Depends on qenc_pkg for the operation type.
interface qenc_in_if;
  import qenc_pkg::*;

  logic valid;
  logic ready;
  op_e  operation;
  logic phase_a;
  logic phase_b;
  logic button_level;

  modport source (output valid, output operation, output phase_a, output phase_b,
                  output button_level, input ready);
  modport sink   (input valid, input operation, input phase_a, input phase_b,
                  input button_level, output ready);
endinterface

### sv/qenc_out_if.sv
`timescale 1ns / 1ps
// Result channel of the encoder decoder: valid, ready and one result beat.
// Depends on qenc_pkg for the field widths.
interface qenc_out_if;
  import qenc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [CountW-1:0] detents;
  logic                     pressed;

  modport source (output valid, output detents, output pressed, input ready);
  modport sink   (input valid, input detents, input pressed, output ready);
endinterface

### sv/quadrature_encoder_with_button_top.sv
`timescale 1ns / 1ps
// Top level of the quadrature encoder decoder with debounced push button.
// Depends on qenc_pkg, qenc_in_if and qenc_out_if.
//
//   Channel   Direction  Handshake            Beat contents
//   in_if     sink       valid / ready        operation, phase_a, phase_b, button_level
//   out_if    source     valid / ready        detents, pressed
//   cfg       input      cfg_we_i (no ready)  cfg_index_i, cfg_data_i
//
// One beat is taken per cycle while in_if.ready is high. A beat lands in the
// input register at the accepting edge and is processed while it sits there;
// a read's result then enters the output register, which drives out_if.valid.
// The single output register is the only limit: a read waits in the input
// register while an earlier result is stalled, and ticks and inits pass on.
// Reset clears the decoder state and reloads both configuration registers.
module quadrature_encoder_with_button_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [qenc_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [qenc_pkg::CfgDataW-1:0]     cfg_data_i,
  qenc_in_if.sink                           in_if,
  qenc_out_if.source                        out_if
);
  import qenc_pkg::*;

  // Configuration registers.
  logic [ShiftW-1:0]    steps_log2_q;
  logic [DebounceW-1:0] debounce_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_log2_q     <= ShiftReset;
      debounce_limit_q <= DebounceReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_STEPS_LOG2: steps_log2_q     <= cfg_data_i[ShiftW-1:0];
        CFG_DEBOUNCE:   debounce_limit_q <= cfg_data_i[DebounceW-1:0];
        default: ;
      endcase
    end
  end

  // Input register. The payload carries no reset; only its valid flag does.
  logic in_vld_q;
  op_e  op_q;
  logic phase_a_q;
  logic phase_b_q;
  logic button_q;

  // Output register.
  logic                     out_vld_q;
  logic signed [CountW-1:0] detents_q;
  logic                     pressed_q;

  // Decoder state.
  pos_t                     last_pos_q,   last_pos_d;
  logic signed [CountW-1:0] step_q,       step_d;
  logic                     stable_q,     stable_d;
  logic [DebounceW-1:0]     db_count_q,   db_count_d;
  logic                     press_q,      press_d;

  logic                     produces;
  logic                     out_free;
  logic                     advance;
  logic signed [CountW-1:0] detents_d;
  logic                     pressed_d;

  // A beat in the input register leaves when it makes no result or when the
  // output register is empty or being emptied in this cycle.
  assign produces    = in_vld_q && (op_q == OP_READ_DETENTS || op_q == OP_READ_PRESS);
  assign out_free    = !out_vld_q || out_if.ready;
  assign advance     = in_vld_q && (out_free || !produces);
  assign in_if.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_if.ready) begin
      in_vld_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      op_q      <= in_if.operation;
      phase_a_q <= in_if.phase_a;
      phase_b_q <= in_if.phase_b;
      button_q  <= in_if.button_level;
    end
  end

  // Per-beat processing: next decoder state and the result fields.
  always_comb begin
    pos_t                 now;
    pos_t                 diff;
    logic                 active;
    logic [DebounceW-1:0] count_inc;
    logic [CountW-1:0]    mask;

    last_pos_d = last_pos_q;
    step_d     = step_q;
    stable_d   = stable_q;
    db_count_d = db_count_q;
    press_d    = press_q;
    detents_d  = '0;
    pressed_d  = 1'b0;

    now       = gray_position(phase_a_q, phase_b_q);
    diff      = last_pos_q - now;
    active    = !button_q;
    count_inc = db_count_q + DebounceW'(1);
    mask      = (CountW'(1) << steps_log2_q) - CountW'(1);

    if (advance) begin
      case (op_q)
        OP_TICK: begin
          // A single step moves the count; a two-step jump is ignored.
          if (diff[0]) begin
            last_pos_d = now;
            step_d     = diff[1] ? step_q + CountW'(1) : step_q - CountW'(1);
          end
          if (active != stable_q) begin
            db_count_d = count_inc;
            if (count_inc == debounce_limit_q) begin
              stable_d = !stable_q;
              if (!stable_q) begin
                press_d = 1'b1;
              end
            end
          end else begin
            db_count_d = '0;
          end
        end
        OP_READ_DETENTS: begin
          detents_d = step_q >>> steps_log2_q;
          step_d    = step_q & mask;
        end
        OP_READ_PRESS: begin
          pressed_d = press_q;
          press_d   = 1'b0;
        end
        OP_INIT: begin
          step_d     = '0;
          last_pos_d = now;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_pos_q <= '0;
      step_q     <= '0;
      stable_q   <= 1'b0;
      db_count_q <= '0;
      press_q    <= 1'b0;
    end else begin
      last_pos_q <= last_pos_d;
      step_q     <= step_d;
      stable_q   <= stable_d;
      db_count_q <= db_count_d;
      press_q    <= press_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && produces) begin
      out_vld_q <= 1'b1;
    end else if (out_if.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && produces) begin
      detents_q <= detents_d;
      pressed_q <= pressed_d;
    end
  end

  assign out_if.valid   = out_vld_q;
  assign out_if.detents = detents_q;
  assign out_if.pressed = pressed_q;

`ifndef ASSERT_OFF
  // The debounced state only changes on a processed tick.
  a_stable_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stable_q != $past(stable_q)) |-> $past(advance && op_q == OP_TICK))
    else $error("debounced button changed without a tick");

  // A press is latched exactly when the debounced state enters pressed.
  a_press_on_flip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(press_q) |-> $rose(stable_q))
    else $error("press latched without a debounced press");

  // A processed press read always leaves the flag clear.
  a_press_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && op_q == OP_READ_PRESS) |=> !press_q)
    else $error("press flag not cleared by a read");

  // Input back-pressure only arises from a read held behind a stalled result.
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_if.ready |-> (produces && out_vld_q && !out_if.ready))
    else $error("input stalled without a blocked result");
`endif

endmodule
